// ===== hdl/hfisqd_pkg.sv =====
// Shared constants and types for the square-wave injection demodulator.
`timescale 1ns / 1ps
`default_nettype none

package hfisqd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PERIOD_BITS_DEF = 12;

   localparam int COEF_W      = 17;
   localparam int GAIN_W      = 16;
   localparam int OUT_W       = 16;
   localparam int ACC_W       = 32;
   localparam int ANGLE_W     = 24;
   localparam int ANGLE_FRAC  = 8;
   localparam int FILT_FRAC   = 8;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int MP_W        = 18;
   localparam int PROD_SHIFT  = 16;

   localparam int RST_HALF_PERIOD = 10;
   localparam int RST_DELAY       = 0;
   localparam logic [COEF_W-1:0] RST_RECIP = 17'd6554;
   localparam logic [COEF_W-1:0] RST_ALPHA = 17'd3277;
   localparam logic [GAIN_W-1:0] RST_GAIN  = 16'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HALF_PERIOD = 3'd0,
      CSR_DELAY       = 3'd1,
      CSR_RECIP       = 3'd2,
      CSR_ALPHA       = 3'd3,
      CSR_GAIN        = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hdl/hfi_square_wave_demodulator.sv =====
// Square-wave injection position observer: demodulator, low-pass and angle integrator.
`timescale 1ns / 1ps
`default_nettype none

// One q-axis current request is taken per control period and yields one response
// carrying the angle estimate, filtered and raw error, the half-period-done flag and
// the injection polarity. The products of each request run on one shared
// signed-by-unsigned multiplier that retires two multiplier bits per cycle:
// one product per ordinary request, three when the half period closes. The
// response sits in an output register, so a new request is accepted while the
// previous response waits, but not while a request is still being computed.
// The user must write registers through the csr port only while no request is
// in flight; the block itself does not enforce this.
module hfi_square_wave_demodulator
   import hfisqd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_current_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic        [OUT_W-1:0]            rsp_angle_estimate,
   output logic signed [OUT_W-1:0]            rsp_error_filtered_out,
   output logic signed [OUT_W-1:0]            rsp_error_raw_out,
   output logic                               rsp_half_period_done,
   output logic                               rsp_inject_positive,
   input  wire logic                          csr_write_en,
   input  wire logic   [CSR_INDEX_W-1:0]      csr_index,
   input  wire logic   [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int FILT_W    = SAMPLE_BITS + FILT_FRAC;
   localparam int DIFF_W    = SAMPLE_BITS + 9;
   localparam int MC_W      = (DIFF_W > ACC_W) ? DIFF_W : ACC_W;
   localparam int HI_W      = MC_W + 2;
   localparam int PROD_W    = HI_W + MP_W;
   localparam int RND_W     = PROD_W - PROD_SHIFT;
   localparam int FS_W      = RND_W + 1;
   localparam int SUM_W     = ACC_W + 1;
   localparam int CLAMP_W   = FILT_W;
   localparam int MUL_STEPS = MP_W / 2;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   localparam logic signed [RND_W-1:0] RAW_MAX =
      RND_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RND_W-1:0] RAW_MIN = ~RAW_MAX;
   localparam logic signed [FS_W-1:0] FILT_MAX =
      FS_W'((longint'(1) <<< (FILT_W - 1)) - 1);
   localparam logic signed [FS_W-1:0] FILT_MIN = ~FILT_MAX;
   localparam logic signed [SUM_W-1:0] ACC_MAX =
      SUM_W'((longint'(1) <<< (ACC_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic signed [CLAMP_W-1:0] OUT_MAX =
      CLAMP_W'((longint'(1) <<< (OUT_W - 1)) - 1);
   localparam logic signed [CLAMP_W-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic signed [PROD_W-1:0] ROUND_C =
      PROD_W'(longint'(1) <<< (PROD_SHIFT - 1));
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_RAW,
      S_RAW_UPD,
      S_DIFF_LD,
      S_MUL_FILT,
      S_FILT_UPD,
      S_MUL_STEP,
      S_ANGLE,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [PERIOD_BITS-1:0] half_period_ff, half_period_in;
   logic [PERIOD_BITS-1:0] delay_ff, delay_in;
   logic [COEF_W-1:0]      recip_ff, recip_in;
   logic [COEF_W-1:0]      alpha_ff, alpha_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;

   logic [PERIOD_BITS-1:0] phase_ff, phase_in;
   logic                   inject_par_ff, inject_par_in;
   logic [PERIOD_BITS-1:0] delay_wait_ff, delay_wait_in;
   logic [PERIOD_BITS-1:0] dphase_ff, dphase_in;
   logic                   dpar_ff, dpar_in;
   logic signed [ACC_W-1:0]       corr_ff, corr_in;
   logic signed [SAMPLE_BITS-1:0] raw_ff, raw_in;
   logic signed [FILT_W-1:0]      filt_ff, filt_in;
   logic [ANGLE_W-1:0]            angle_ff, angle_in;
   logic                          done_ff, done_in;

   logic signed [MC_W-1:0]   mc_ff, mc_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]          rsp_angle_ff, rsp_angle_in;
   logic signed [OUT_W-1:0]   rsp_filt_ff, rsp_filt_in;
   logic signed [OUT_W-1:0]   rsp_raw_ff, rsp_raw_in;
   logic                      rsp_done_ff, rsp_done_in;
   logic                      rsp_inj_ff, rsp_inj_in;

   logic                   accept;
   logic                   delay_hold;
   logic [PERIOD_BITS:0]   dphase_inc, phase_inc;
   logic                   dwrap, done_now, ref_neg;
   logic signed [SUM_W-1:0] sample_x, corr_x, corr_sum;
   logic signed [ACC_W-1:0] corr_sat;

   logic signed [HI_W-1:0]   mc_x, mul_hi, add0, add1, hi_sum;
   logic signed [PROD_W-1:0] mul_cat, mul_shift;
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [RND_W-1:0]  rnd;
   logic signed [SAMPLE_BITS-1:0] raw_sat;
   logic signed [DIFF_W-1:0] raw_x256, diff;
   logic signed [FS_W-1:0]   filt_sum;
   logic signed [FILT_W-1:0] filt_sat;
   logic [ANGLE_W-1:0]       angle_step;
   logic signed [CLAMP_W-1:0] filt_sh, raw_ext;
   logic signed [OUT_W-1:0]  filt_out, raw_out;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      // reference and injection timebases
      delay_hold = delay_wait_ff < delay_ff;
      dphase_inc = {1'b0, dphase_ff} + (PERIOD_BITS + 1)'(1);
      dwrap      = dphase_inc >= {1'b0, half_period_ff};
      phase_inc  = {1'b0, phase_ff} + (PERIOD_BITS + 1)'(1);
      done_now   = phase_inc >= {1'b0, half_period_ff};
      ref_neg    = !delay_hold && (dpar_ff ^ dwrap);

      sample_x = SUM_W'(req_current_sample);
      corr_x   = SUM_W'(corr_ff);
      corr_sum = ref_neg ? (corr_x - sample_x) : (corr_x + sample_x);
      if (corr_sum > ACC_MAX) begin
         corr_sat = ACC_MAX[ACC_W-1:0];
      end else if (corr_sum < ACC_MIN) begin
         corr_sat = ACC_MIN[ACC_W-1:0];
      end else begin
         corr_sat = corr_sum[ACC_W-1:0];
      end

      // two multiplier bits per cycle, shift-add
      mc_x      = HI_W'(mc_ff);
      mul_hi    = $signed(mul_ff[PROD_W-1:MP_W]);
      add0      = mul_ff[0] ? mc_x : '0;
      add1      = mul_ff[1] ? (mc_x <<< 1) : '0;
      hi_sum    = mul_hi + add0 + add1;
      mul_cat   = {hi_sum, mul_ff[MP_W-1:0]};
      mul_shift = mul_cat >>> 2;

      rnd_full = (mul_ff + ROUND_C) >>> PROD_SHIFT;
      rnd      = $signed(rnd_full[RND_W-1:0]);
      if (rnd > RAW_MAX) begin
         raw_sat = RAW_MAX[SAMPLE_BITS-1:0];
      end else if (rnd < RAW_MIN) begin
         raw_sat = RAW_MIN[SAMPLE_BITS-1:0];
      end else begin
         raw_sat = rnd[SAMPLE_BITS-1:0];
      end

      raw_x256 = $signed({raw_ff[SAMPLE_BITS-1], raw_ff, 8'h00});
      diff     = raw_x256 - DIFF_W'(filt_ff);

      filt_sum = FS_W'(filt_ff) + FS_W'(rnd);
      if (filt_sum > FILT_MAX) begin
         filt_sat = FILT_MAX[FILT_W-1:0];
      end else if (filt_sum < FILT_MIN) begin
         filt_sat = FILT_MIN[FILT_W-1:0];
      end else begin
         filt_sat = filt_sum[FILT_W-1:0];
      end

      angle_step = mul_ff[PROD_SHIFT +: ANGLE_W];

      filt_sh = filt_ff >>> FILT_FRAC;
      if (filt_sh > OUT_MAX) begin
         filt_out = OUT_MAX[OUT_W-1:0];
      end else if (filt_sh < OUT_MIN) begin
         filt_out = OUT_MIN[OUT_W-1:0];
      end else begin
         filt_out = filt_sh[OUT_W-1:0];
      end

      raw_ext = CLAMP_W'(raw_ff);
      if (raw_ext > OUT_MAX) begin
         raw_out = OUT_MAX[OUT_W-1:0];
      end else if (raw_ext < OUT_MIN) begin
         raw_out = OUT_MIN[OUT_W-1:0];
      end else begin
         raw_out = raw_ext[OUT_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      half_period_in = half_period_ff;
      delay_in       = delay_ff;
      recip_in       = recip_ff;
      alpha_in       = alpha_ff;
      gain_in        = gain_ff;
      phase_in       = phase_ff;
      inject_par_in  = inject_par_ff;
      delay_wait_in  = delay_wait_ff;
      dphase_in      = dphase_ff;
      dpar_in        = dpar_ff;
      corr_in        = corr_ff;
      raw_in         = raw_ff;
      filt_in        = filt_ff;
      angle_in       = angle_ff;
      done_in        = done_ff;
      mc_in          = mc_ff;
      mul_in         = mul_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_angle_in   = rsp_angle_ff;
      rsp_filt_in    = rsp_filt_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_inj_in     = rsp_inj_ff;

      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_HALF_PERIOD: half_period_in = csr_wdata[PERIOD_BITS-1:0];
            CSR_DELAY:       delay_in       = csr_wdata[PERIOD_BITS-1:0];
            CSR_RECIP:       recip_in       = csr_wdata[COEF_W-1:0];
            CSR_ALPHA:       alpha_in       = csr_wdata[COEF_W-1:0];
            CSR_GAIN:        gain_in        = csr_wdata[GAIN_W-1:0];
            default:         ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (delay_hold) begin
                  delay_wait_in = delay_wait_ff + PERIOD_BITS'(1);
               end else if (dwrap) begin
                  dphase_in = '0;
                  dpar_in   = !dpar_ff;
               end else begin
                  dphase_in = dphase_inc[PERIOD_BITS-1:0];
               end
               if (done_now) begin
                  phase_in      = '0;
                  inject_par_in = !inject_par_ff;
               end else begin
                  phase_in = phase_inc[PERIOD_BITS-1:0];
               end
               done_in = done_now;
               cnt_in  = '0;
               if (done_now) begin
                  corr_in  = '0;
                  mc_in    = MC_W'(corr_sat);
                  mul_in   = {{HI_W{1'b0}}, MP_W'(recip_ff)};
                  state_in = S_MUL_RAW;
               end else begin
                  corr_in  = corr_sat;
                  mc_in    = MC_W'(filt_ff);
                  mul_in   = {{HI_W{1'b0}}, MP_W'(gain_ff)};
                  state_in = S_MUL_STEP;
               end
            end
         end
         S_MUL_RAW: begin
            mul_in = mul_shift;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_RAW_UPD;
            end
         end
         S_RAW_UPD: begin
            raw_in   = raw_sat;
            state_in = S_DIFF_LD;
         end
         S_DIFF_LD: begin
            mc_in    = MC_W'(diff);
            mul_in   = {{HI_W{1'b0}}, MP_W'(alpha_ff)};
            cnt_in   = '0;
            state_in = S_MUL_FILT;
         end
         S_MUL_FILT: begin
            mul_in = mul_shift;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_FILT_UPD;
            end
         end
         S_FILT_UPD: begin
            filt_in  = filt_sat;
            mc_in    = MC_W'(filt_sat);
            mul_in   = {{HI_W{1'b0}}, MP_W'(gain_ff)};
            cnt_in   = '0;
            state_in = S_MUL_STEP;
         end
         S_MUL_STEP: begin
            mul_in = mul_shift;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            angle_in = angle_ff + angle_step;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff[ANGLE_FRAC +: OUT_W];
               rsp_filt_in  = filt_out;
               rsp_raw_in   = raw_out;
               rsp_done_in  = done_ff;
               rsp_inj_in   = !inject_par_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         half_period_ff <= PERIOD_BITS'(RST_HALF_PERIOD);
         delay_ff       <= PERIOD_BITS'(RST_DELAY);
         recip_ff       <= RST_RECIP;
         alpha_ff       <= RST_ALPHA;
         gain_ff        <= RST_GAIN;
         phase_ff       <= '0;
         inject_par_ff  <= 1'b0;
         delay_wait_ff  <= '0;
         dphase_ff      <= '0;
         dpar_ff        <= 1'b0;
         corr_ff        <= '0;
         raw_ff         <= '0;
         filt_ff        <= '0;
         angle_ff       <= '0;
         done_ff        <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         half_period_ff <= half_period_in;
         delay_ff       <= delay_in;
         recip_ff       <= recip_in;
         alpha_ff       <= alpha_in;
         gain_ff        <= gain_in;
         phase_ff       <= phase_in;
         inject_par_ff  <= inject_par_in;
         delay_wait_ff  <= delay_wait_in;
         dphase_ff      <= dphase_in;
         dpar_ff        <= dpar_in;
         corr_ff        <= corr_in;
         raw_ff         <= raw_in;
         filt_ff        <= filt_in;
         angle_ff       <= angle_in;
         done_ff        <= done_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mc_ff        <= mc_in;
      mul_ff       <= mul_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_raw_ff   <= rsp_raw_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_inj_ff   <= rsp_inj_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_angle_estimate     = rsp_angle_ff;
   assign rsp_error_filtered_out = rsp_filt_ff;
   assign rsp_error_raw_out      = rsp_raw_ff;
   assign rsp_half_period_done   = rsp_done_ff;
   assign rsp_inject_positive    = rsp_inj_ff;

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

   a_corr_clear : assert property (@(posedge clock) disable iff (reset)
      (accept && done_now) |=> (corr_ff == '0))
      else $error("correlation sum not cleared at half-period end");

   a_angle_after_mul : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ANGLE) |-> $past(state_ff == S_MUL_STEP && cnt_ff == CNT_LAST))
      else $error("angle update without a finished step product");

endmodule

`default_nettype wire

// ===== tb/hfisqd_checker.sv =====
// Checker for the square-wave injection demodulator: predicts each response and compares it.
`timescale 1ns / 1ps

module hfisqd_checker
   import hfisqd_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [SAMPLE_BITS_DEF-1:0] req_current_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic        [OUT_W-1:0]           rsp_angle_estimate,
   input  logic signed [OUT_W-1:0]           rsp_error_filtered_out,
   input  logic signed [OUT_W-1:0]           rsp_error_raw_out,
   input  logic                              rsp_half_period_done,
   input  logic                              rsp_inject_positive,
   input  logic                              csr_write_en,
   input  logic        [CSR_INDEX_W-1:0]     csr_index,
   input  logic        [CSR_DATA_W-1:0]      csr_wdata,
   output int                                fail_count,
   output int                                pending,
   output int                                checked_count,
   output int                                closed_count
);

   typedef struct packed {
      logic [OUT_W-1:0] angle;
      logic [OUT_W-1:0] err_filt;
      logic [OUT_W-1:0] err_raw;
      logic             done;
      logic             inj_pos;
   } estimate_type;

   logic [PERIOD_BITS_DEF-1:0] cfg_half;
   logic [PERIOD_BITS_DEF-1:0] cfg_delay;
   logic [COEF_W-1:0]          cfg_recip;
   logic [COEF_W-1:0]          cfg_alpha;
   logic [GAIN_W-1:0]          cfg_gain;

   logic [PERIOD_BITS_DEF-1:0] inj_count;
   logic                       inj_par;
   logic [PERIOD_BITS_DEF-1:0] ref_wait;
   logic [PERIOD_BITS_DEF-1:0] ref_count;
   logic                       ref_par;
   longint                     corr_acc;
   longint                     err_raw;
   longint                     err_filt;
   logic [ANGLE_W-1:0]         theta;

   estimate_type pending_estimates[$];

   function automatic longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic estimate_type demodulate(logic signed [SAMPLE_BITS_DEF-1:0] sample);
      longint value;
      longint polarity;
      longint product;
      longint diff;
      longint step;
      estimate_type est;
      value = sample;
      polarity = 1;
      est.done = 1'b0;
      // reference runs behind the injection; +1 until the delay has elapsed
      if (ref_wait < cfg_delay) begin
         ref_wait = ref_wait + 1'b1;
      end else begin
         if (int'(ref_count) + 1 >= int'(cfg_half)) begin
            ref_count = '0;
            ref_par = ~ref_par;
         end else begin
            ref_count = ref_count + 1'b1;
         end
         if (ref_par) polarity = -1;
      end
      corr_acc = saturate(corr_acc + polarity * value, ACC_W);
      if (int'(inj_count) + 1 >= int'(cfg_half)) begin
         inj_count = '0;
         inj_par = ~inj_par;
         est.done = 1'b1;
      end else begin
         inj_count = inj_count + 1'b1;
      end
      if (est.done) begin
         product = corr_acc * longint'(cfg_recip);
         err_raw = saturate((product + 32768) >>> PROD_SHIFT, SAMPLE_BITS_DEF);
         diff = err_raw * 256 - err_filt;
         err_filt = saturate(err_filt + ((diff * longint'(cfg_alpha) + 32768) >>> PROD_SHIFT),
                             SAMPLE_BITS_DEF + FILT_FRAC);
         corr_acc = 0;
      end
      step = (longint'(cfg_gain) * err_filt) >>> PROD_SHIFT;
      theta = theta + step[ANGLE_W-1:0];
      est.angle = theta[ANGLE_W-1 -: OUT_W];
      est.err_filt = OUT_W'(saturate(err_filt >>> FILT_FRAC, OUT_W));
      est.err_raw = OUT_W'(saturate(err_raw, OUT_W));
      est.inj_pos = ~inj_par;
      return est;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      estimate_type est;
      if (reset) begin
         cfg_half = PERIOD_BITS_DEF'(RST_HALF_PERIOD);
         cfg_delay = PERIOD_BITS_DEF'(RST_DELAY);
         cfg_recip = RST_RECIP;
         cfg_alpha = RST_ALPHA;
         cfg_gain = RST_GAIN;
         inj_count = '0;
         inj_par = 1'b0;
         ref_wait = '0;
         ref_count = '0;
         ref_par = 1'b0;
         corr_acc = 0;
         err_raw = 0;
         err_filt = 0;
         theta = '0;
         fail_count = 0;
         checked_count = 0;
         closed_count = 0;
         pending_estimates.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_estimates.size() == 0) begin
               $display("%0t ns: response with no request outstanding", $time);
               fail_count++;
            end else begin
               est = pending_estimates.pop_front();
               check_field("angle_estimate", int'(est.angle), int'(rsp_angle_estimate));
               check_field("error_filtered_out", int'($signed(est.err_filt)),
                           int'(rsp_error_filtered_out));
               check_field("error_raw_out", int'($signed(est.err_raw)),
                           int'(rsp_error_raw_out));
               check_field("half_period_done", int'(est.done), int'(rsp_half_period_done));
               check_field("inject_positive", int'(est.inj_pos), int'(rsp_inject_positive));
               checked_count++;
               if (est.done) closed_count++;
            end
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_HALF_PERIOD: cfg_half = csr_wdata[PERIOD_BITS_DEF-1:0];
               CSR_DELAY:       cfg_delay = csr_wdata[PERIOD_BITS_DEF-1:0];
               CSR_RECIP:       cfg_recip = csr_wdata[COEF_W-1:0];
               CSR_ALPHA:       cfg_alpha = csr_wdata[COEF_W-1:0];
               CSR_GAIN:        cfg_gain = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) pending_estimates.push_back(demodulate(req_current_sample));
      end
      pending = pending_estimates.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the square-wave injection demodulator: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_top
   import hfisqd_pkg::*;
();

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [SAMPLE_BITS_DEF-1:0] req_current_sample = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic        [OUT_W-1:0]           rsp_angle_estimate;
   logic signed [OUT_W-1:0]           rsp_error_filtered_out;
   logic signed [OUT_W-1:0]           rsp_error_raw_out;
   logic                              rsp_half_period_done;
   logic                              rsp_inject_positive;
   logic                              csr_write_en = 1'b0;
   csr_index_type                     csr_index = CSR_HALF_PERIOD;
   logic        [CSR_DATA_W-1:0]      csr_wdata = '0;

   int fail_count;
   int pending;
   int checked_count;
   int closed_count;

   int req_gap_pct = 21;
   int rsp_stall_pct = 75;
   int samples_sent = 0;
   int setting_count = 0;
   int cur_half = RST_HALF_PERIOD;

   always #4 clock = ~clock;

   hfi_square_wave_demodulator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_current_sample(req_current_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_angle_estimate(rsp_angle_estimate),
      .rsp_error_filtered_out(rsp_error_filtered_out),
      .rsp_error_raw_out(rsp_error_raw_out),
      .rsp_half_period_done(rsp_half_period_done),
      .rsp_inject_positive(rsp_inject_positive),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   hfisqd_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_current_sample(req_current_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_angle_estimate(rsp_angle_estimate),
      .rsp_error_filtered_out(rsp_error_filtered_out),
      .rsp_error_raw_out(rsp_error_raw_out),
      .rsp_half_period_done(rsp_half_period_done),
      .rsp_inject_positive(rsp_inject_positive),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending),
      .checked_count(checked_count),
      .closed_count(closed_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic program_regs(int unsigned half, int unsigned dly, int unsigned recip,
                               int unsigned alpha, int unsigned gain);
      csr_write_en <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= CSR_DATA_W'(half);
      @(posedge clock);
      csr_index <= CSR_DELAY;
      csr_wdata <= CSR_DATA_W'(dly);
      @(posedge clock);
      csr_index <= CSR_RECIP;
      csr_wdata <= CSR_DATA_W'(recip);
      @(posedge clock);
      csr_index <= CSR_ALPHA;
      csr_wdata <= CSR_DATA_W'(alpha);
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_W'(gain);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_half = half;
      setting_count++;
   endtask

   task automatic send_sample(logic signed [SAMPLE_BITS_DEF-1:0] sample);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_current_sample <= sample;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // hold off new requests until every outstanding response has been taken
   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS_DEF-1:0] next_sample(int k, int amp);
      int span;
      int v;
      span = (cur_half == 0) ? 1 : cur_half;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: begin
            v = (((k / span) % 2) != 0) ? -amp : amp;
            v = v + $urandom_range(511) - 256;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
         end
         7: begin
            case ($urandom_range(3))
               0: v = 32767;
               1: v = -32768;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v[SAMPLE_BITS_DEF-1:0];
   endfunction

   initial begin
      int half;
      int dly;
      int recip;
      int alpha;
      int gain;
      int amp;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      // zero half period: every sample closes one; unity alpha, full gain
      drain();
      program_regs(0, 0, 65536, 65536, 65535);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd12345);
      // alpha zero holds the filter, delayed reference
      drain();
      program_regs(3, 2, 21845, 0, 40000);
      send_sample(16'sd20000);
      send_sample(-16'sd20000);
      send_sample(16'sd30000);
      send_sample(-16'sd5);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      // run counters up, then shrink the half period below them and raise the delay
      drain();
      program_regs(8, 2, 8192, 30000, 20000);
      send_sample(16'sd1000);
      send_sample(16'sd2000);
      send_sample(-16'sd3000);
      send_sample(16'sd4000);
      send_sample(16'sd5000);
      drain();
      program_regs(2, 6, 32768, 30000, 20000);
      send_sample(16'sd32767);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      // alpha above one overshoots and saturates the filter
      drain();
      program_regs(1, 0, 65536, 100000, 65535);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);

      for (int seg = 0; seg < 9; seg++) begin
         if (seg == 3) begin
            req_gap_pct = 75;
            rsp_stall_pct = 21;
         end else if (seg == 6) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         if (seg == 1) begin
            half = 4095;
            dly = 4095;
            recip = 1;
            alpha = 1;
            gain = 65535;
         end else begin
            case ($urandom_range(9))
               0: half = $urandom_range(1);
               1: half = $urandom_range(100, 400);
               default: half = $urandom_range(2, 40);
            endcase
            dly = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(20);
            if (half == 0 || $urandom_range(4) == 0) recip = $urandom_range(1, 65536);
            else recip = (65536 + half / 2) / half;
            case ($urandom_range(5))
               0: alpha = 65536;
               1: alpha = 1;
               default: alpha = $urandom_range(1, 65536);
            endcase
            case ($urandom_range(5))
               0: gain = 65535;
               1: gain = 0;
               default: gain = $urandom_range(65535);
            endcase
         end
         drain();
         program_regs(half, dly, recip, alpha, gain);
         amp = $urandom_range(32767);
         for (int k = 0; k < 72; k++) send_sample(next_sample(k, amp));
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d current samples across %0d register settings and three idle patterns.",
               samples_sent, setting_count);
      $display("Compared %0d responses, %0d of them closing a half period.",
               checked_count, closed_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/hfisqd_pkg.sv
hdl/hfi_square_wave_demodulator.sv
tb/hfisqd_checker.sv
tb/tb_top.sv
